FILE: hw/rtl/cpt_pkg.sv
package cpt_pkg;

   localparam int LINE_BITS      = 16;
   localparam int COLUMN_BITS    = 12;
   localparam int MAX_TOKENS     = 4;
   localparam int TOK_IDX_BITS   = $clog2(MAX_TOKENS);
   localparam int TOK_CNT_BITS   = $clog2(MAX_TOKENS + 1);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   localparam logic [5:0] KIND_LPAREN      = 6'd0;
   localparam logic [5:0] KIND_RPAREN      = 6'd1;
   localparam logic [5:0] KIND_LBRACK      = 6'd2;
   localparam logic [5:0] KIND_RBRACK      = 6'd3;
   localparam logic [5:0] KIND_LBRACE      = 6'd4;
   localparam logic [5:0] KIND_RBRACE      = 6'd5;
   localparam logic [5:0] KIND_QUEST       = 6'd6;
   localparam logic [5:0] KIND_COMMA       = 6'd7;
   localparam logic [5:0] KIND_TILDE       = 6'd8;
   localparam logic [5:0] KIND_SEMI        = 6'd9;
   localparam logic [5:0] KIND_HASH        = 6'd10;
   localparam logic [5:0] KIND_COLON       = 6'd11;
   localparam logic [5:0] KIND_MINUS       = 6'd12;
   localparam logic [5:0] KIND_PLUS        = 6'd13;
   localparam logic [5:0] KIND_LT          = 6'd14;
   localparam logic [5:0] KIND_PCT         = 6'd15;
   localparam logic [5:0] KIND_GT          = 6'd16;
   localparam logic [5:0] KIND_ASSIGN      = 6'd17;
   localparam logic [5:0] KIND_BANG        = 6'd18;
   localparam logic [5:0] KIND_AMP         = 6'd19;
   localparam logic [5:0] KIND_BAR         = 6'd20;
   localparam logic [5:0] KIND_STAR        = 6'd21;
   localparam logic [5:0] KIND_SLASH       = 6'd22;
   localparam logic [5:0] KIND_CARET       = 6'd23;
   localparam logic [5:0] KIND_DOT         = 6'd24;
   localparam logic [5:0] KIND_ARROW       = 6'd25;
   localparam logic [5:0] KIND_DEC         = 6'd26;
   localparam logic [5:0] KIND_SUB_ASSIGN  = 6'd27;
   localparam logic [5:0] KIND_INC         = 6'd28;
   localparam logic [5:0] KIND_ADD_ASSIGN  = 6'd29;
   localparam logic [5:0] KIND_SHL         = 6'd30;
   localparam logic [5:0] KIND_SHL_ASSIGN  = 6'd31;
   localparam logic [5:0] KIND_LE          = 6'd32;
   localparam logic [5:0] KIND_SHR         = 6'd33;
   localparam logic [5:0] KIND_SHR_ASSIGN  = 6'd34;
   localparam logic [5:0] KIND_GE          = 6'd35;
   localparam logic [5:0] KIND_EQ          = 6'd36;
   localparam logic [5:0] KIND_NE          = 6'd37;
   localparam logic [5:0] KIND_LAND        = 6'd38;
   localparam logic [5:0] KIND_AND_ASSIGN  = 6'd39;
   localparam logic [5:0] KIND_LOR         = 6'd40;
   localparam logic [5:0] KIND_OR_ASSIGN   = 6'd41;
   localparam logic [5:0] KIND_MUL_ASSIGN  = 6'd42;
   localparam logic [5:0] KIND_DIV_ASSIGN  = 6'd43;
   localparam logic [5:0] KIND_XOR_ASSIGN  = 6'd44;
   localparam logic [5:0] KIND_MOD_ASSIGN  = 6'd45;
   localparam logic [5:0] KIND_ELLIPSIS    = 6'd46;
   localparam logic [5:0] KIND_HASHHASH    = 6'd47;
   localparam logic [5:0] KIND_INVALID     = 6'd48;
   localparam logic [5:0] KIND_END         = 6'd49;
   localparam logic [5:0] KIND_COMMENT_ERR = 6'd50;

   typedef enum logic [4:0] {
      PFX_NONE, PFX_MINUS, PFX_PLUS, PFX_LT, PFX_LTLT, PFX_GT, PFX_GTGT, PFX_EQ, PFX_BANG,
      PFX_AMP, PFX_BAR, PFX_STAR, PFX_CARET, PFX_SLASH, PFX_DOT, PFX_DOTDOT, PFX_HASH,
      PFX_COLON, PFX_PCT, PFX_PCTCOLON, PFX_PCTCOLONPCT
   } pfx_type;

   typedef enum logic [1:0] {
      CMT_NONE, CMT_LINE, CMT_BLOCK
   } cmt_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]             token_kind;
      logic [LINE_BITS-1:0]   start_line;
      logic [COLUMN_BITS-1:0] start_column;
      logic                   space_before;
      logic                   last_of_run;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_TOKENS-1:0] tok;
      logic [TOK_CNT_BITS-1:0]  count;
   } bundle_type;

   typedef struct packed {
      pfx_type                pfx;
      cmt_type                cmt;
      logic                   star_seen;
      logic                   splice_pending;
      logic                   space_flag;
      logic [LINE_BITS-1:0]   line_count;
      logic [COLUMN_BITS-1:0] column_count;
      logic [LINE_BITS-1:0]   tok_line;
      logic [COLUMN_BITS-1:0] tok_column;
      logic [LINE_BITS-1:0]   mid_line;
      logic [COLUMN_BITS-1:0] mid_column;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      bundle_type    tk;
      logic          taken;
   } lex_work_type;

   localparam lex_state_type LEX_RESET = '{
      pfx: PFX_NONE, cmt: CMT_NONE, star_seen: 1'b0, splice_pending: 1'b0,
      space_flag: 1'b0, line_count: LINE_ONE, column_count: COL_ONE,
      tok_line: LINE_ONE, tok_column: COL_ONE, mid_line: LINE_ONE, mid_column: COL_ONE
   };

   function automatic lex_work_type lex_emit(lex_work_type w, logic [5:0] kind,
                                             logic [LINE_BITS-1:0] ln,
                                             logic [COLUMN_BITS-1:0] col);
      lex_work_type r;
      rsp_type      item;
      r = w;
      item.token_kind   = kind;
      item.start_line   = ln;
      item.start_column = col;
      item.space_before = r.st.space_flag;
      item.last_of_run  = 1'b0;
      if (r.tk.count < TOK_CNT_BITS'(MAX_TOKENS)) begin
         r.tk.tok[r.tk.count[TOK_IDX_BITS-1:0]] = item;
         r.tk.count = r.tk.count + TOK_CNT_BITS'(1);
      end
      r.st.space_flag = 1'b0;
      return r;
   endfunction

   function automatic lex_work_type lex_advance(lex_work_type w, logic [7:0] c);
      lex_work_type r;
      r = w;
      if (c == CH_NL) begin
         if (r.st.line_count != LINE_MAX) r.st.line_count = r.st.line_count + LINE_ONE;
         r.st.column_count = COL_ONE;
      end else if (r.st.column_count != COL_MAX) begin
         r.st.column_count = r.st.column_count + COL_ONE;
      end
      return r;
   endfunction

   function automatic lex_work_type lex_set(lex_work_type w, pfx_type p);
      lex_work_type r;
      r = w;
      r.st.pfx        = p;
      r.st.tok_line   = r.st.line_count;
      r.st.tok_column = r.st.column_count;
      return r;
   endfunction

   // c is NUL at end of input: no prefix continues with it
   function automatic lex_work_type lex_resolve(lex_work_type w, logic [7:0] c);
      lex_work_type r;
      logic         to_comment;
      logic [5:0]   full_kind;
      logic [5:0]   single_kind;
      pfx_type      next_pfx;
      r           = w;
      to_comment  = 1'b0;
      full_kind   = KIND_INVALID;
      single_kind = KIND_INVALID;
      next_pfx    = PFX_NONE;
      r.taken     = 1'b0;
      if (r.st.pfx == PFX_DOTDOT && c != CH_DOT) begin
         r = lex_emit(r, KIND_DOT, r.st.tok_line, r.st.tok_column);
         r.st.pfx        = PFX_DOT;
         r.st.tok_line   = r.st.mid_line;
         r.st.tok_column = r.st.mid_column;
      end else if (r.st.pfx == PFX_PCTCOLONPCT && c != CH_COLON) begin
         r = lex_emit(r, KIND_HASH, r.st.tok_line, r.st.tok_column);
         r.st.pfx        = PFX_PCT;
         r.st.tok_line   = r.st.mid_line;
         r.st.tok_column = r.st.mid_column;
      end
      case (r.st.pfx)
         PFX_MINUS: begin
            single_kind = KIND_MINUS;
            if (c == CH_GT) full_kind = KIND_ARROW;
            else if (c == CH_MINUS) full_kind = KIND_DEC;
            else if (c == CH_EQUAL) full_kind = KIND_SUB_ASSIGN;
         end
         PFX_PLUS: begin
            single_kind = KIND_PLUS;
            if (c == CH_PLUS) full_kind = KIND_INC;
            else if (c == CH_EQUAL) full_kind = KIND_ADD_ASSIGN;
         end
         PFX_LT: begin
            single_kind = KIND_LT;
            if (c == CH_LT) next_pfx = PFX_LTLT;
            else if (c == CH_EQUAL) full_kind = KIND_LE;
            else if (c == CH_COLON) full_kind = KIND_LBRACK;
            else if (c == CH_PCT) full_kind = KIND_LBRACE;
         end
         PFX_LTLT: begin
            single_kind = KIND_SHL;
            if (c == CH_EQUAL) full_kind = KIND_SHL_ASSIGN;
         end
         PFX_GT: begin
            single_kind = KIND_GT;
            if (c == CH_GT) next_pfx = PFX_GTGT;
            else if (c == CH_EQUAL) full_kind = KIND_GE;
         end
         PFX_GTGT: begin
            single_kind = KIND_SHR;
            if (c == CH_EQUAL) full_kind = KIND_SHR_ASSIGN;
         end
         PFX_EQ: begin
            single_kind = KIND_ASSIGN;
            if (c == CH_EQUAL) full_kind = KIND_EQ;
         end
         PFX_BANG: begin
            single_kind = KIND_BANG;
            if (c == CH_EQUAL) full_kind = KIND_NE;
         end
         PFX_AMP: begin
            single_kind = KIND_AMP;
            if (c == CH_AMP) full_kind = KIND_LAND;
            else if (c == CH_EQUAL) full_kind = KIND_AND_ASSIGN;
         end
         PFX_BAR: begin
            single_kind = KIND_BAR;
            if (c == CH_BAR) full_kind = KIND_LOR;
            else if (c == CH_EQUAL) full_kind = KIND_OR_ASSIGN;
         end
         PFX_STAR: begin
            single_kind = KIND_STAR;
            if (c == CH_EQUAL) full_kind = KIND_MUL_ASSIGN;
         end
         PFX_CARET: begin
            single_kind = KIND_CARET;
            if (c == CH_EQUAL) full_kind = KIND_XOR_ASSIGN;
         end
         PFX_SLASH: begin
            single_kind = KIND_SLASH;
            if (c == CH_SLASH || c == CH_STAR) to_comment = 1'b1;
            else if (c == CH_EQUAL) full_kind = KIND_DIV_ASSIGN;
         end
         PFX_DOT: begin
            single_kind = KIND_DOT;
            if (c == CH_DOT) begin
               next_pfx        = PFX_DOTDOT;
               r.st.mid_line   = r.st.line_count;
               r.st.mid_column = r.st.column_count;
            end
         end
         PFX_DOTDOT: full_kind = KIND_ELLIPSIS;
         PFX_HASH: begin
            single_kind = KIND_HASH;
            if (c == CH_HASH) full_kind = KIND_HASHHASH;
         end
         PFX_COLON: begin
            single_kind = KIND_COLON;
            if (c == CH_GT) full_kind = KIND_RBRACK;
         end
         PFX_PCT: begin
            single_kind = KIND_PCT;
            if (c == CH_COLON) next_pfx = PFX_PCTCOLON;
            else if (c == CH_EQUAL) full_kind = KIND_MOD_ASSIGN;
            else if (c == CH_GT) full_kind = KIND_RBRACE;
         end
         PFX_PCTCOLON: begin
            single_kind = KIND_HASH;
            if (c == CH_PCT) begin
               next_pfx        = PFX_PCTCOLONPCT;
               r.st.mid_line   = r.st.line_count;
               r.st.mid_column = r.st.column_count;
            end
         end
         PFX_PCTCOLONPCT: full_kind = KIND_HASHHASH;
         default: single_kind = KIND_INVALID;
      endcase
      if (r.st.pfx == PFX_NONE) begin
         r.taken = 1'b0;
      end else if (to_comment) begin
         r.st.cmt        = (c == CH_SLASH) ? CMT_LINE : CMT_BLOCK;
         r.st.star_seen  = 1'b0;
         r.st.space_flag = 1'b1;
         r.st.pfx        = PFX_NONE;
         r.taken         = 1'b1;
      end else if (next_pfx != PFX_NONE) begin
         r.st.pfx = next_pfx;
         r.taken  = 1'b1;
      end else if (full_kind != KIND_INVALID) begin
         r.st.pfx = PFX_NONE;
         r        = lex_emit(r, full_kind, r.st.tok_line, r.st.tok_column);
         r.taken  = 1'b1;
      end else begin
         r.st.pfx = PFX_NONE;
         r        = lex_emit(r, single_kind, r.st.tok_line, r.st.tok_column);
         r.taken  = 1'b0;
      end
      return r;
   endfunction

   function automatic lex_work_type lex_fresh(lex_work_type w, logic [7:0] c);
      lex_work_type r;
      r = w;
      case (c) inside
         CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: r.st.space_flag = 1'b1;
         CH_LPAREN: r = lex_emit(r, KIND_LPAREN, r.st.line_count, r.st.column_count);
         CH_RPAREN: r = lex_emit(r, KIND_RPAREN, r.st.line_count, r.st.column_count);
         CH_LBRACK: r = lex_emit(r, KIND_LBRACK, r.st.line_count, r.st.column_count);
         CH_RBRACK: r = lex_emit(r, KIND_RBRACK, r.st.line_count, r.st.column_count);
         CH_LBRACE: r = lex_emit(r, KIND_LBRACE, r.st.line_count, r.st.column_count);
         CH_RBRACE: r = lex_emit(r, KIND_RBRACE, r.st.line_count, r.st.column_count);
         CH_QUEST:  r = lex_emit(r, KIND_QUEST, r.st.line_count, r.st.column_count);
         CH_COMMA:  r = lex_emit(r, KIND_COMMA, r.st.line_count, r.st.column_count);
         CH_TILDE:  r = lex_emit(r, KIND_TILDE, r.st.line_count, r.st.column_count);
         CH_SEMI:   r = lex_emit(r, KIND_SEMI, r.st.line_count, r.st.column_count);
         CH_MINUS:  r = lex_set(r, PFX_MINUS);
         CH_PLUS:   r = lex_set(r, PFX_PLUS);
         CH_LT:     r = lex_set(r, PFX_LT);
         CH_GT:     r = lex_set(r, PFX_GT);
         CH_EQUAL:  r = lex_set(r, PFX_EQ);
         CH_BANG:   r = lex_set(r, PFX_BANG);
         CH_AMP:    r = lex_set(r, PFX_AMP);
         CH_BAR:    r = lex_set(r, PFX_BAR);
         CH_STAR:   r = lex_set(r, PFX_STAR);
         CH_CARET:  r = lex_set(r, PFX_CARET);
         CH_SLASH:  r = lex_set(r, PFX_SLASH);
         CH_DOT:    r = lex_set(r, PFX_DOT);
         CH_HASH:   r = lex_set(r, PFX_HASH);
         CH_COLON:  r = lex_set(r, PFX_COLON);
         CH_PCT:    r = lex_set(r, PFX_PCT);
         default:   r = lex_emit(r, KIND_INVALID, r.st.line_count, r.st.column_count);
      endcase
      return r;
   endfunction

   function automatic lex_work_type lex_char(lex_work_type w, logic [7:0] c);
      lex_work_type r;
      r = w;
      case (r.st.cmt)
         CMT_LINE: begin
            if (c == CH_NL) begin
               r.st.cmt        = CMT_NONE;
               r.st.space_flag = 1'b1;
            end
         end
         CMT_BLOCK: begin
            if (r.st.star_seen && c == CH_SLASH) begin
               r.st.cmt       = CMT_NONE;
               r.st.star_seen = 1'b0;
            end else begin
               r.st.star_seen = (c == CH_STAR);
            end
         end
         default: begin
            r = lex_resolve(r, c);
            if (!r.taken) r = lex_fresh(r, c);
         end
      endcase
      r = lex_advance(r, c);
      return r;
   endfunction

   function automatic lex_work_type lex_step(lex_state_type s, req_type q);
      lex_work_type            r;
      logic                    eoi;
      logic                    skip;
      logic [TOK_IDX_BITS-1:0] last_idx;
      r.st    = s;
      r.tk    = '0;
      r.taken = 1'b0;
      skip    = 1'b0;
      eoi     = q.end_of_input || (q.byte_in == CH_NUL);
      if (eoi) begin
         if (r.st.splice_pending) begin
            r.st.splice_pending = 1'b0;
            r = lex_char(r, CH_BSLASH);
         end
         if (r.st.cmt == CMT_BLOCK) r = lex_emit(r, KIND_COMMENT_ERR, r.st.tok_line,
                                                  r.st.tok_column);
         else if (r.st.cmt == CMT_NONE) r = lex_resolve(r, CH_NUL);
         r    = lex_emit(r, KIND_END, r.st.line_count, r.st.column_count);
         r.st = LEX_RESET;
      end else begin
         if (r.st.splice_pending) begin
            r.st.splice_pending = 1'b0;
            if (q.byte_in == CH_NL) begin
               r    = lex_advance(r, CH_NL);
               skip = 1'b1;
            end else begin
               r = lex_char(r, CH_BSLASH);
            end
         end
         if (!skip) begin
            if (q.byte_in == CH_BSLASH) r.st.splice_pending = 1'b1;
            else r = lex_char(r, q.byte_in);
         end
      end
      last_idx = TOK_IDX_BITS'(r.tk.count - TOK_CNT_BITS'(1));
      if (r.tk.count != '0) r.tk.tok[last_idx].last_of_run = 1'b1;
      return r;
   endfunction

endpackage

FILE: hw/rtl/cpt_lexer.sv
module cpt_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  cpt_pkg::req_type    req_data,
   output cpt_pkg::bundle_type bundle
);
   import cpt_pkg::*;

   lex_state_type state_ff;
   lex_state_type state_in;
   lex_work_type  work;

   assign work   = lex_step(state_ff, req_data);
   assign bundle = work.tk;

   always_comb begin
      state_in = state_ff;
      if (req_fire) state_in = work.st;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= LEX_RESET;
      else state_ff <= state_in;
   end

   a_prefix_outside_comment: assert property (@(posedge clock) disable iff (reset)
      state_ff.cmt != CMT_NONE |-> state_ff.pfx == PFX_NONE)
      else $error("pending prefix held inside a comment");

   a_star_only_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff.star_seen |-> state_ff.cmt == CMT_BLOCK)
      else $error("star flag set outside a block comment");

   a_position_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.line_count != '0 && state_ff.column_count != '0)
      else $error("line or column counter reached zero");

endmodule

FILE: hw/rtl/cpt_queue.sv
module cpt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpt_pkg::bundle_type push_data,
   output logic                push_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpt_pkg::rsp_type    rsp_data
);
   import cpt_pkg::*;

   bundle_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [TOK_IDX_BITS-1:0]   idx_ff, idx_in;
   bundle_type                head;
   logic                      pop;
   logic                      head_done;

   assign head       = entries_ff[rd_ptr_ff];
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = head.tok[idx_ff];
   assign push_ready = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign pop        = rsp_valid && rsp_ready;
   assign head_done  = pop && ({1'b0, idx_ff} == head.count - TOK_CNT_BITS'(1));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      if (push) wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(1);
      if (head_done) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(1);
         idx_in    = '0;
      end else if (pop) begin
         idx_in = idx_ff + TOK_IDX_BITS'(1);
      end
      if (push && !head_done) count_in = count_ff + QUEUE_CNT_BITS'(1);
      else if (!push && head_done) count_in = count_ff - QUEUE_CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_data;
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("transaction pushed into a full queue");

   a_head_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> head.count != '0)
      else $error("queued group holds no token");

   a_index_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, idx_ff} < head.count)
      else $error("token index past end of group");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

FILE: hw/rtl/c_punctuator_tokenizer_core.sv
// Punctuator lexer for C source: one source byte is taken per req transaction, every cycle
// req_ready is high, and tokens leave on rsp one per transaction. A byte is lexed in the
// cycle it is accepted and its zero to four tokens enter a two-entry queue of token
// groups, so an empty queue offers the first token the cycle after its byte; a byte that
// yields n tokens takes n rsp transactions, and req_ready drops only while both queue
// entries are occupied. last_of_run marks the final token of one byte; a zero byte or
// end_of_input flushes the pending token, emits the end token, and resets the lexer.
module c_punctuator_tokenizer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpt_pkg::rsp_type rsp_data
);
   import cpt_pkg::*;

   bundle_type bundle;
   logic       req_fire;
   logic       push;

   assign req_fire = req_valid && req_ready;
   assign push     = req_fire && (bundle.count != '0);

   cpt_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .bundle   (bundle)
   );

   cpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (bundle),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: sim/tb_checker.sv
`timescale 1ns / 1ps

module tb_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cpt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cpt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               tokens_left,
   output int               tokens_seen
);
   import cpt_pkg::*;

   pfx_type                pfx;
   cmt_type                cmt;
   logic                   in_star;
   logic                   held_bslash;
   logic                   gap_seen;
   logic [LINE_BITS-1:0]   cur_line;
   logic [LINE_BITS-1:0]   tok_line;
   logic [LINE_BITS-1:0]   mid_line;
   logic [COLUMN_BITS-1:0] cur_col;
   logic [COLUMN_BITS-1:0] tok_col;
   logic [COLUMN_BITS-1:0] mid_col;

   rsp_type                run_tok [MAX_TOKENS];
   int                     run_len;
   rsp_type                token_fifo [$];
   rsp_type                want;

   function automatic void clear_lexer();
      pfx         = PFX_NONE;
      cmt         = CMT_NONE;
      in_star     = 1'b0;
      held_bslash = 1'b0;
      gap_seen    = 1'b0;
      cur_line    = LINE_ONE;
      tok_line    = LINE_ONE;
      mid_line    = LINE_ONE;
      cur_col     = COL_ONE;
      tok_col     = COL_ONE;
      mid_col     = COL_ONE;
   endfunction

   function automatic void push_token(logic [5:0] kind, logic [LINE_BITS-1:0] ln,
                                      logic [COLUMN_BITS-1:0] col);
      rsp_type t;
      t.token_kind   = kind;
      t.start_line   = ln;
      t.start_column = col;
      t.space_before = gap_seen;
      t.last_of_run  = 1'b0;
      if (run_len < MAX_TOKENS) begin
         run_tok[run_len] = t;
         run_len++;
      end
      gap_seen = 1'b0;
   endfunction

   function automatic void bump_pos(logic [7:0] c);
      if (c == CH_NL) begin
         if (cur_line != LINE_MAX) cur_line = cur_line + LINE_ONE;
         cur_col = COL_ONE;
      end else if (cur_col != COL_MAX) begin
         cur_col = cur_col + COL_ONE;
      end
   endfunction

   // c is -1 at end of input; returns 1 when c was absorbed by the pending prefix
   function automatic bit pfx_apply(int c);
      int      full;
      int      single;
      pfx_type nxt;
      bit      again;
      bit      to_cmt;
      bit      taken;
      taken = 1'b0;
      do begin
         full   = -1;
         single = -1;
         nxt    = PFX_NONE;
         again  = 1'b0;
         to_cmt = 1'b0;
         case (pfx)
            PFX_MINUS: begin
               single = KIND_MINUS;
               if (c == CH_GT) full = KIND_ARROW;
               else if (c == CH_MINUS) full = KIND_DEC;
               else if (c == CH_EQUAL) full = KIND_SUB_ASSIGN;
            end
            PFX_PLUS: begin
               single = KIND_PLUS;
               if (c == CH_PLUS) full = KIND_INC;
               else if (c == CH_EQUAL) full = KIND_ADD_ASSIGN;
            end
            PFX_LT: begin
               single = KIND_LT;
               if (c == CH_LT) nxt = PFX_LTLT;
               else if (c == CH_EQUAL) full = KIND_LE;
               else if (c == CH_COLON) full = KIND_LBRACK;
               else if (c == CH_PCT) full = KIND_LBRACE;
            end
            PFX_LTLT: begin
               single = KIND_SHL;
               if (c == CH_EQUAL) full = KIND_SHL_ASSIGN;
            end
            PFX_GT: begin
               single = KIND_GT;
               if (c == CH_GT) nxt = PFX_GTGT;
               else if (c == CH_EQUAL) full = KIND_GE;
            end
            PFX_GTGT: begin
               single = KIND_SHR;
               if (c == CH_EQUAL) full = KIND_SHR_ASSIGN;
            end
            PFX_EQ: begin
               single = KIND_ASSIGN;
               if (c == CH_EQUAL) full = KIND_EQ;
            end
            PFX_BANG: begin
               single = KIND_BANG;
               if (c == CH_EQUAL) full = KIND_NE;
            end
            PFX_AMP: begin
               single = KIND_AMP;
               if (c == CH_AMP) full = KIND_LAND;
               else if (c == CH_EQUAL) full = KIND_AND_ASSIGN;
            end
            PFX_BAR: begin
               single = KIND_BAR;
               if (c == CH_BAR) full = KIND_LOR;
               else if (c == CH_EQUAL) full = KIND_OR_ASSIGN;
            end
            PFX_STAR: begin
               single = KIND_STAR;
               if (c == CH_EQUAL) full = KIND_MUL_ASSIGN;
            end
            PFX_CARET: begin
               single = KIND_CARET;
               if (c == CH_EQUAL) full = KIND_XOR_ASSIGN;
            end
            PFX_SLASH: begin
               single = KIND_SLASH;
               if (c == CH_SLASH || c == CH_STAR) to_cmt = 1'b1;
               else if (c == CH_EQUAL) full = KIND_DIV_ASSIGN;
            end
            PFX_DOT: begin
               single = KIND_DOT;
               if (c == CH_DOT) begin
                  nxt      = PFX_DOTDOT;
                  mid_line = cur_line;
                  mid_col  = cur_col;
               end
            end
            PFX_DOTDOT: begin
               if (c == CH_DOT) begin
                  full = KIND_ELLIPSIS;
               end else begin
                  push_token(KIND_DOT, tok_line, tok_col);
                  pfx      = PFX_DOT;
                  tok_line = mid_line;
                  tok_col  = mid_col;
                  again    = 1'b1;
               end
            end
            PFX_HASH: begin
               single = KIND_HASH;
               if (c == CH_HASH) full = KIND_HASHHASH;
            end
            PFX_COLON: begin
               single = KIND_COLON;
               if (c == CH_GT) full = KIND_RBRACK;
            end
            PFX_PCT: begin
               single = KIND_PCT;
               if (c == CH_COLON) nxt = PFX_PCTCOLON;
               else if (c == CH_EQUAL) full = KIND_MOD_ASSIGN;
               else if (c == CH_GT) full = KIND_RBRACE;
            end
            PFX_PCTCOLON: begin
               single = KIND_HASH;
               if (c == CH_PCT) begin
                  nxt      = PFX_PCTCOLONPCT;
                  mid_line = cur_line;
                  mid_col  = cur_col;
               end
            end
            PFX_PCTCOLONPCT: begin
               if (c == CH_COLON) begin
                  full = KIND_HASHHASH;
               end else begin
                  push_token(KIND_HASH, tok_line, tok_col);
                  pfx      = PFX_PCT;
                  tok_line = mid_line;
                  tok_col  = mid_col;
                  again    = 1'b1;
               end
            end
            default: ;
         endcase
         if (!again) begin
            if (pfx == PFX_NONE) begin
               taken = 1'b0;
            end else if (to_cmt) begin
               if (c == CH_SLASH) cmt = CMT_LINE;
               else cmt = CMT_BLOCK;
               in_star  = 1'b0;
               gap_seen = 1'b1;
               pfx      = PFX_NONE;
               taken    = 1'b1;
            end else if (nxt != PFX_NONE) begin
               pfx   = nxt;
               taken = 1'b1;
            end else begin
               pfx = PFX_NONE;
               if (full >= 0) begin
                  push_token(6'(full), tok_line, tok_col);
                  taken = 1'b1;
               end else begin
                  push_token(6'(single), tok_line, tok_col);
                  taken = 1'b0;
               end
            end
         end
      end while (again);
      return taken;
   endfunction

   function automatic void classify(logic [7:0] c);
      logic [5:0] kind;
      pfx_type    p;
      logic       is_ws;
      kind  = KIND_INVALID;
      p     = PFX_NONE;
      is_ws = 1'b0;
      case (c) inside
         CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: is_ws = 1'b1;
         CH_LPAREN: kind = KIND_LPAREN;
         CH_RPAREN: kind = KIND_RPAREN;
         CH_LBRACK: kind = KIND_LBRACK;
         CH_RBRACK: kind = KIND_RBRACK;
         CH_LBRACE: kind = KIND_LBRACE;
         CH_RBRACE: kind = KIND_RBRACE;
         CH_QUEST:  kind = KIND_QUEST;
         CH_COMMA:  kind = KIND_COMMA;
         CH_TILDE:  kind = KIND_TILDE;
         CH_SEMI:   kind = KIND_SEMI;
         CH_MINUS:  p = PFX_MINUS;
         CH_PLUS:   p = PFX_PLUS;
         CH_LT:     p = PFX_LT;
         CH_GT:     p = PFX_GT;
         CH_EQUAL:  p = PFX_EQ;
         CH_BANG:   p = PFX_BANG;
         CH_AMP:    p = PFX_AMP;
         CH_BAR:    p = PFX_BAR;
         CH_STAR:   p = PFX_STAR;
         CH_CARET:  p = PFX_CARET;
         CH_SLASH:  p = PFX_SLASH;
         CH_DOT:    p = PFX_DOT;
         CH_HASH:   p = PFX_HASH;
         CH_COLON:  p = PFX_COLON;
         CH_PCT:    p = PFX_PCT;
         default: ;
      endcase
      if (is_ws) begin
         gap_seen = 1'b1;
      end else if (p != PFX_NONE) begin
         pfx      = p;
         tok_line = cur_line;
         tok_col  = cur_col;
      end else begin
         push_token(kind, cur_line, cur_col);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      if (cmt == CMT_LINE) begin
         if (c == CH_NL) begin
            cmt      = CMT_NONE;
            gap_seen = 1'b1;
         end
      end else if (cmt == CMT_BLOCK) begin
         if (in_star && c == CH_SLASH) begin
            cmt     = CMT_NONE;
            in_star = 1'b0;
         end else begin
            in_star = (c == CH_STAR);
         end
      end else if (!pfx_apply(int'(c))) begin
         classify(c);
      end
      bump_pos(c);
   endfunction

   function automatic void predict_tokens(req_type q);
      logic eoi;
      logic skip;
      bit   unused;
      int   i;
      run_len = 0;
      skip    = 1'b0;
      eoi     = q.end_of_input || (q.byte_in == CH_NUL);
      if (eoi) begin
         if (held_bslash) begin
            held_bslash = 1'b0;
            lex_byte(CH_BSLASH);
         end
         if (cmt == CMT_BLOCK) push_token(KIND_COMMENT_ERR, tok_line, tok_col);
         else if (cmt == CMT_NONE) unused = pfx_apply(-1);
         push_token(KIND_END, cur_line, cur_col);
         clear_lexer();
      end else begin
         if (held_bslash) begin
            held_bslash = 1'b0;
            if (q.byte_in == CH_NL) begin
               bump_pos(CH_NL);
               skip = 1'b1;
            end else begin
               lex_byte(CH_BSLASH);
            end
         end
         if (!skip) begin
            if (q.byte_in == CH_BSLASH) held_bslash = 1'b1;
            else lex_byte(q.byte_in);
         end
      end
      if (run_len > 0) run_tok[run_len-1].last_of_run = 1'b1;
      for (i = 0; i < run_len; i++) token_fifo = {token_fifo, run_tok[i]};
   endfunction

   function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (want_v !== got_v) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_lexer();
         token_fifo.delete();
         fail_count  = 0;
         tokens_seen = 0;
      end else begin
         if (req_valid && req_ready) predict_tokens(req_data);
         if (rsp_valid && rsp_ready) begin
            if (token_fifo.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: token expected none actual kind %0d line %0d column %0d",
                           $time, rsp_data.token_kind, rsp_data.start_line,
                           rsp_data.start_column);
            end else begin
               want = token_fifo.pop_front();
               check_field("token_kind", 16'(want.token_kind), 16'(rsp_data.token_kind));
               check_field("start_line", 16'(want.start_line), 16'(rsp_data.start_line));
               check_field("start_column", 16'(want.start_column),
                           16'(rsp_data.start_column));
               check_field("space_before", 16'(want.space_before),
                           16'(rsp_data.space_before));
               check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_data.last_of_run));
               tokens_seen++;
            end
         end
      end
      tokens_left = token_fifo.size();
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import cpt_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BYTES = 420;
   localparam int PUNCT_COUNT  = 54;

   logic    clock     = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      fail_count;
   int      tokens_left;
   int      tokens_seen;
   int      cycle_count = 0;
   int      bytes_sent  = 0;
   int      ends_sent   = 0;
   int      byte_target;
   int      k;
   bit      req_burst   = 1'b0;
   bit      rsp_burst   = 1'b0;
   int      rsp_hold    = 0;

   always #5 clock = ~clock;

   c_punctuator_tokenizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .tokens_left (tokens_left),
      .tokens_seen (tokens_seen)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_burst && $urandom_range(0, 3) == 0) rsp_hold <= pick_gap();
      end
      if ($urandom_range(0, 199) == 0) rsp_burst <= !rsp_burst;
   end

   function automatic string punct_text(int idx);
      case (idx)
         0: return "(";    1: return ")";    2: return "[";    3: return "]";
         4: return "{";    5: return "}";    6: return "?";    7: return ",";
         8: return "~";    9: return ";";    10: return "#";   11: return ":";
         12: return "-";   13: return "+";   14: return "<";   15: return "%";
         16: return ">";   17: return "=";   18: return "!";   19: return "&";
         20: return "|";   21: return "*";   22: return "/";   23: return "^";
         24: return ".";   25: return "->";  26: return "--";  27: return "-=";
         28: return "++";  29: return "+=";  30: return "<<";  31: return "<<=";
         32: return "<=";  33: return ">>";  34: return ">>=";  35: return ">=";
         36: return "==";  37: return "!=";  38: return "&&";  39: return "&=";
         40: return "||";  41: return "|=";  42: return "*=";  43: return "/=";
         44: return "^=";  45: return "%=";  46: return "...";  47: return "##";
         48: return "<:";  49: return ":>";  50: return "<%";  51: return "%>";
         52: return "%:";  default: return "%:%:";
      endcase
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return CH_NL;
         2: return CH_VT;
         3: return CH_FF;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] comment_byte();
      case ($urandom_range(0, 9))
         0: return CH_STAR;
         1: return CH_SLASH;
         2: return CH_BSLASH;
         3: return CH_NL;
         4: return CH_SPACE;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic send_byte(logic [7:0] b, logic eoi);
      req_type t;
      int      gap;
      t.byte_in      = b;
      t.end_of_input = eoi;
      gap            = req_burst ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= t;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      bytes_sent++;
      if (eoi || b == CH_NUL) ends_sent++;
   endtask

   task automatic send_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic send_end();
      if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      else send_byte(CH_NUL, 1'b0);
   endtask

   task automatic send_punct(int idx);
      string s;
      int    i;
      s = punct_text(idx);
      if ($urandom_range(0, 2) == 0) send_byte(pick_space(), 1'b0);
      for (i = 0; i < s.len(); i++) begin
         if (i == 1 && $urandom_range(0, 7) == 0) send_text("\\\n");
         send_byte(s[i], 1'b0);
      end
   endtask

   task automatic send_fragment();
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) req_burst = !req_burst;
      if (pick < 55) begin
         send_punct($urandom_range(0, PUNCT_COUNT - 1));
      end else if (pick < 62) begin
         send_text("//");
         repeat ($urandom_range(0, 8)) send_byte(comment_byte(), 1'b0);
         send_byte(CH_NL, 1'b0);
      end else if (pick < 70) begin
         send_text("/*");
         repeat ($urandom_range(0, 8)) send_byte(comment_byte(), 1'b0);
         if ($urandom_range(0, 5) != 0) send_text("*/");
         else send_end();
      end else if (pick < 75) begin
         if ($urandom_range(0, 1) == 0) send_text("..");
         else send_text("%:%");
      end else if (pick < 80) begin
         send_byte(CH_BSLASH, 1'b0);
      end else if (pick < 86) begin
         send_byte(pick_space(), 1'b0);
      end else if (pick < 93) begin
         send_byte(8'($urandom_range(1, 255)), 1'b0);
      end else begin
         send_end();
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_text("(");
      send_text("-\\\n>");
      send_text("..,");
      send_text("%:%=");
      send_text("\\x");
      send_byte(8'hFF, 1'b0);
      send_text("/*/ */");
      send_text("<\\");
      send_byte(8'h41, 1'b1);
      send_text("/* ");
      send_byte(CH_NUL, 1'b0);

      byte_target = bytes_sent + RANDOM_BYTES;
      for (k = 0; k < PUNCT_COUNT; k++) send_punct(k);
      while (bytes_sent < byte_target) send_fragment();
      req_burst = 1'b0;
      send_end();
      req_valid <= 1'b0;

      do begin
         @(posedge clock);
      end while (tokens_left != 0);
      repeat (20) @(posedge clock);

      $display("Sent %0d source bytes with %0d end markers; %0d tokens compared.",
               bytes_sent, ends_sent, tokens_seen);
      $display("Stream mixed all punctuators and digraphs, comments, splices, backtracking "
               , "and noise bytes under random stalls on both channels.");
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
